// ===== src/aff_pkg.sv =====
// shared types and constants for the affine point transform
`timescale 1ns / 1ps
`default_nettype none

package aff_pkg;

  // fraction bits of the fixed point format
  localparam int FRAC_BITS_DEF = 16;

  // coordinate, product and divider widths
  localparam int CW    = 32;
  localparam int PW    = 65;
  localparam int SW    = 67;
  localparam int MW    = 65;
  localparam int DW    = 64;
  localparam int QW    = 33;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // configuration port
  localparam int CFG_AW = 5;

  // mode codes
  localparam logic MODE_FWD = 1'b0;
  localparam logic MODE_INV = 1'b1;

  // register indexes
  typedef enum logic [2:0] {
    REG_COEF_A  = 3'd0,
    REG_COEF_B  = 3'd1,
    REG_SHIFT_X = 3'd2,
    REG_COEF_C  = 3'd3,
    REG_COEF_D  = 3'd4,
    REG_SHIFT_Y = 3'd5
  } cfg_reg_t;

  // matrix and translation
  typedef struct packed {
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    logic signed [CW-1:0] tx;
    logic signed [CW-1:0] c;
    logic signed [CW-1:0] d;
    logic signed [CW-1:0] ty;
  } coef_t;

  // item classified by the front, waiting in the queue
  typedef struct packed {
    logic          mode;
    logic          sing;
    logic [CW-1:0] fx;
    logic [CW-1:0] fy;
    logic          fovf;
    logic          negx;
    logic          negy;
    logic [MW-1:0] magx;
    logic [MW-1:0] magy;
  } ent_t;

  // item fields carried along the divider
  typedef struct packed {
    logic          mode;
    logic          sing;
    logic [CW-1:0] fx;
    logic [CW-1:0] fy;
    logic          fovf;
    logic          negx;
    logic          negy;
  } pay_t;

  // one divider lane
  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QW-1:0] low;
    logic [QW-1:0] quo;
    logic          ovf;
  } lane_t;

endpackage

`default_nettype wire

// ===== src/aff_in_if.sv =====
// input point channel
`timescale 1ns / 1ps
`default_nettype none

interface aff_in_if;
  logic                             valid;
  logic                             ready;
  logic                             mode;
  logic signed [aff_pkg::CW-1:0]    in_x;
  logic signed [aff_pkg::CW-1:0]    in_y;

  modport source (output valid, output mode, output in_x, output in_y, input ready);
  modport sink   (input valid, input mode, input in_x, input in_y, output ready);
endinterface

`default_nettype wire

// ===== src/aff_out_if.sv =====
// result point channel
`timescale 1ns / 1ps
`default_nettype none

interface aff_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [aff_pkg::CW-1:0]    out_x;
  logic signed [aff_pkg::CW-1:0]    out_y;
  logic                             singular;
  logic                             overflow;

  modport source (output valid, output out_x, output out_y, output singular,
                  output overflow, input ready);
  modport sink   (input valid, input out_x, input out_y, input singular,
                  input overflow, output ready);
endinterface

`default_nettype wire

// ===== src/aff_front.sv =====
// front pipeline: products, forward results and inverse numerators
`timescale 1ns / 1ps
`default_nettype none

module aff_front #(
  parameter int FRAC_BITS = aff_pkg::FRAC_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  aff_pkg::coef_t               coef,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire                          in_mode,
  input  wire  signed [aff_pkg::CW-1:0] in_x,
  input  wire  signed [aff_pkg::CW-1:0] in_y,
  output logic                         push,
  output aff_pkg::ent_t                push_ent,
  input  wire                          q_full,
  output logic [aff_pkg::DW-1:0]       den
);

  localparam int SW = aff_pkg::SW;
  localparam int PW = aff_pkg::PW;
  localparam int MW = aff_pkg::MW;
  localparam int CW = aff_pkg::CW;
  localparam int DW = aff_pkg::DW;
  localparam logic signed [SW-1:0] RND = SW'(1) << (FRAC_BITS - 1);

  // forward coordinate: shift the rounded sum, translate, saturate; returns {ovf, value}
  function automatic logic [CW:0] fwd_coord(input logic signed [SW-1:0] e,
                                            input logic signed [CW-1:0] t);
    logic signed [SW-1:0] r;
    logic [SW-CW:0]       hi;
    r  = (e >>> FRAC_BITS) + SW'(t);
    hi = r[SW-1:CW-1];
    if (&hi || ~|hi) begin
      fwd_coord = {1'b0, r[CW-1:0]};
    end else if (r[SW-1]) begin
      fwd_coord = {1'b1, 1'b1, {(CW-1){1'b0}}};
    end else begin
      fwd_coord = {1'b1, 1'b0, {(CW-1){1'b1}}};
    end
  endfunction

  logic                        f_en;

  // determinant, follows the registers
  logic signed [63:0]          ad_r, bc_r;
  logic signed [64:0]          det_r;
  logic [DW-1:0]               den_r;
  logic                        det_neg_r, det_zero_r;

  logic                        v1_r, v2_r, v3_r, v4_r, v5_r;
  logic                        m1_r, m2_r, m3_r, m4_r;
  logic signed [CW-1:0]        x1_r, y1_r;
  logic signed [CW:0]          opa_r, opb_r, opc_r, opd_r;
  logic signed [PW-1:0]        pa_r, pb_r, pc_r, pd_r;
  logic signed [SW-1:0]        e0_r, e1_r;
  logic signed [CW:0]          dx, dy;
  logic [CW:0]                 fcx, fcy;
  aff_pkg::ent_t               ent_r, ent_nxt;

  assign f_en     = !v5_r || !q_full;
  assign in_ready = f_en;
  assign push     = v5_r && f_en;
  assign push_ent = ent_r;
  assign den      = den_r;

  // determinant and divisor magnitude
  always_ff @(posedge clk) begin
    ad_r       <= 64'(coef.a) * 64'(coef.d);
    bc_r       <= 64'(coef.b) * 64'(coef.c);
    det_r      <= 65'(ad_r) - 65'(bc_r);
    det_neg_r  <= det_r[64];
    det_zero_r <= (det_r == '0);
    den_r      <= det_r[64] ? DW'(-det_r) : DW'(det_r);
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (f_en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // differences against the translation
  assign dx = (CW+1)'(x1_r) - (CW+1)'(coef.tx);
  assign dy = (CW+1)'(y1_r) - (CW+1)'(coef.ty);

  // forward results
  assign fcx = fwd_coord(e0_r, coef.tx);
  assign fcy = fwd_coord(e1_r, coef.ty);

  // classified item
  always_comb begin
    ent_nxt      = '0;
    ent_nxt.mode = m4_r;
    ent_nxt.sing = (m4_r == aff_pkg::MODE_INV) && det_zero_r;
    ent_nxt.fx   = fcx[CW-1:0];
    ent_nxt.fy   = fcy[CW-1:0];
    ent_nxt.fovf = fcx[CW] | fcy[CW];
    ent_nxt.negx = e0_r[SW-1] ^ det_neg_r;
    ent_nxt.negy = e1_r[SW-1] ^ det_neg_r;
    ent_nxt.magx = e0_r[SW-1] ? MW'(-e0_r) : MW'(e0_r);
    ent_nxt.magy = e1_r[SW-1] ? MW'(-e1_r) : MW'(e1_r);
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (f_en) begin
      m1_r  <= in_mode;
      x1_r  <= in_x;
      y1_r  <= in_y;
      m2_r  <= m1_r;
      opa_r <= (m1_r == aff_pkg::MODE_INV) ? dy : (CW+1)'(x1_r);
      opb_r <= (m1_r == aff_pkg::MODE_INV) ? dy : (CW+1)'(y1_r);
      opc_r <= (m1_r == aff_pkg::MODE_INV) ? dx : (CW+1)'(x1_r);
      opd_r <= (m1_r == aff_pkg::MODE_INV) ? dx : (CW+1)'(y1_r);
      m3_r  <= m2_r;
      pa_r  <= PW'(coef.a) * PW'(opa_r);
      pb_r  <= PW'(coef.b) * PW'(opb_r);
      pc_r  <= PW'(coef.c) * PW'(opc_r);
      pd_r  <= PW'(coef.d) * PW'(opd_r);
      m4_r  <= m3_r;
      if (m3_r == aff_pkg::MODE_INV) begin
        e0_r <= SW'(pd_r) - SW'(pb_r);
        e1_r <= SW'(pa_r) - SW'(pc_r);
      end else begin
        e0_r <= SW'(pa_r) + SW'(pb_r) + RND;
        e1_r <= SW'(pc_r) + SW'(pd_r) + RND;
      end
      ent_r <= ent_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/aff_queue.sv =====
// short item queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module aff_queue (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            push,
  input  aff_pkg::ent_t  push_ent,
  output logic           full,
  input  wire            pop,
  output aff_pkg::ent_t  pop_ent,
  output logic           empty
);

  localparam int QAW = aff_pkg::QAW;

  aff_pkg::ent_t   mem_r [aff_pkg::QDEPTH];
  logic [QAW-1:0]  wp_r, rp_r;
  logic [QAW:0]    cnt_r;

  assign full    = (cnt_r == (QAW+1)'(aff_pkg::QDEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_ent = mem_r[rp_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_ent;
  end

endmodule

`default_nettype wire

// ===== src/aff_back.sv =====
// back pipeline: bit-per-stage divider and result register
`timescale 1ns / 1ps
`default_nettype none

module aff_back #(
  parameter int FRAC_BITS = aff_pkg::FRAC_BITS_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire  [aff_pkg::DW-1:0]        den,
  input  wire                           q_empty,
  input  aff_pkg::ent_t                 q_ent,
  output logic                          q_pop,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic signed [aff_pkg::CW-1:0] out_x,
  output logic signed [aff_pkg::CW-1:0] out_y,
  output logic                          singular,
  output logic                          overflow
);

  localparam int DW = aff_pkg::DW;
  localparam int QW = aff_pkg::QW;
  localparam int CW = aff_pkg::CW;
  localparam int MW = aff_pkg::MW;
  localparam int NW = MW + FRAC_BITS + 1;

  // quotient to signed saturated coordinate; returns {ovf, value}
  function automatic logic [CW:0] inv_coord(input aff_pkg::lane_t l, input logic neg);
    logic big;
    logic [QW-1:0] nq;
    nq = -l.quo;
    if (neg) begin
      big = l.ovf || l.quo[QW-1] || (l.quo[CW-1] && (|l.quo[CW-2:0]));
    end else begin
      big = l.ovf || l.quo[QW-1] || l.quo[CW-1];
    end
    if (big) begin
      inv_coord = neg ? {1'b1, 1'b1, {(CW-1){1'b0}}} : {1'b1, 1'b0, {(CW-1){1'b1}}};
    end else begin
      inv_coord = neg ? {1'b0, nq[CW-1:0]} : {1'b0, l.quo[CW-1:0]};
    end
  endfunction

  // one restoring step
  function automatic aff_pkg::lane_t div_step(input aff_pkg::lane_t l,
                                              input logic [DW-1:0] dv);
    aff_pkg::lane_t r;
    logic [DW:0]    t;
    r = l;
    t = {l.rem, l.low[QW-1]};
    r.low = {l.low[QW-2:0], 1'b0};
    if (t >= {1'b0, dv}) begin
      t     = t - {1'b0, dv};
      r.quo = {l.quo[QW-2:0], 1'b1};
    end else begin
      r.quo = {l.quo[QW-2:0], 1'b0};
    end
    r.rem = t[DW-1:0];
    div_step = r;
  endfunction

  logic                 b_en;
  logic                 v0_r;
  aff_pkg::pay_t        p0_r;
  logic [NW-1:0]        nx_r, ny_r;

  logic                 sv_r [QW+1];
  aff_pkg::pay_t        sp_r [QW+1];
  aff_pkg::lane_t       lx_r [QW+1];
  aff_pkg::lane_t       ly_r [QW+1];

  aff_pkg::lane_t       lx0, ly0;
  logic [CW:0]          rx, ry;

  logic                 ov_r;
  logic signed [CW-1:0] ox_r, oy_r;
  logic                 osing_r, oovf_r;

  assign b_en      = !ov_r || out_ready;
  assign q_pop     = b_en && !q_empty;
  assign out_valid = ov_r;
  assign out_x     = ox_r;
  assign out_y     = oy_r;
  assign singular  = osing_r;
  assign overflow  = oovf_r;

  // divider start: high part of the numerator against the divisor
  always_comb begin
    lx0     = '0;
    ly0     = '0;
    lx0.rem = DW'(nx_r[NW-1:QW]);
    ly0.rem = DW'(ny_r[NW-1:QW]);
    lx0.low = nx_r[QW-1:0];
    ly0.low = ny_r[QW-1:0];
    lx0.ovf = (lx0.rem >= den);
    ly0.ovf = (ly0.rem >= den);
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      for (int k = 0; k <= QW; k++) sv_r[k] <= 1'b0;
      ov_r <= 1'b0;
    end else if (b_en) begin
      v0_r    <= !q_empty;
      sv_r[0] <= v0_r;
      for (int k = 1; k <= QW; k++) sv_r[k] <= sv_r[k-1];
      ov_r    <= sv_r[QW];
    end
  end

  // numerator with half divisor for rounding, then start stage
  always_ff @(posedge clk) begin
    if (b_en) begin
      p0_r.mode <= q_ent.mode;
      p0_r.sing <= q_ent.sing;
      p0_r.fx   <= q_ent.fx;
      p0_r.fy   <= q_ent.fy;
      p0_r.fovf <= q_ent.fovf;
      p0_r.negx <= q_ent.negx;
      p0_r.negy <= q_ent.negy;
      nx_r      <= NW'({q_ent.magx, {FRAC_BITS{1'b0}}}) + NW'(den >> 1);
      ny_r      <= NW'({q_ent.magy, {FRAC_BITS{1'b0}}}) + NW'(den >> 1);
      sp_r[0]   <= p0_r;
      lx_r[0]   <= lx0;
      ly_r[0]   <= ly0;
    end
  end

  // one quotient bit per stage
  for (genvar k = 1; k <= QW; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (b_en) begin
        sp_r[k] <= sp_r[k-1];
        lx_r[k] <= div_step(lx_r[k-1], den);
        ly_r[k] <= div_step(ly_r[k-1], den);
      end
    end
  end

  assign rx = inv_coord(lx_r[QW], sp_r[QW].negx);
  assign ry = inv_coord(ly_r[QW], sp_r[QW].negy);

  // result register
  always_ff @(posedge clk) begin
    if (b_en) begin
      if (sp_r[QW].mode == aff_pkg::MODE_FWD) begin
        ox_r    <= sp_r[QW].fx;
        oy_r    <= sp_r[QW].fy;
        osing_r <= 1'b0;
        oovf_r  <= sp_r[QW].fovf;
      end else if (sp_r[QW].sing) begin
        ox_r    <= '0;
        oy_r    <= '0;
        osing_r <= 1'b1;
        oovf_r  <= 1'b0;
      end else begin
        ox_r    <= rx[CW-1:0];
        oy_r    <= ry[CW-1:0];
        osing_r <= 1'b0;
        oovf_r  <= rx[CW] | ry[CW];
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/affine_2d_point_transform.sv =====
// top level: register file, front, queue and back of the affine point transform
//
//  channel   direction  handshake           payload
//  in_pt     in         valid/ready         mode, in_x, in_y
//  out_pt    out        valid/ready         out_x, out_y, singular, overflow
//  cfg       in         apb psel/penable    paddr, pwdata, prdata
//
// one item per cycle while neither the queue nor the result stalls, set by the
// five-stage multiply front and the divider pipeline, which finds one quotient bit per stage for both coordinates
// stages: 5 front, queue, 2 divider setup, 33 divider, 1 result register
// reset is synchronous and clears all valids and queue pointers
// a stalled result stops the back only; the front keeps taking items until
// the four-entry queue fills
`timescale 1ns / 1ps
`default_nettype none

module affine_2d_point_transform #(
  parameter int FRAC_BITS = aff_pkg::FRAC_BITS_DEF
) (
  input  wire                        clk,
  input  wire                        rst_n,
  aff_in_if.sink                     in_pt,
  aff_out_if.source                  out_pt,
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire  [aff_pkg::CFG_AW-1:0] paddr,
  input  wire  [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int CW = aff_pkg::CW;
  localparam logic signed [CW-1:0] ONE = CW'(1) << FRAC_BITS;

  aff_pkg::coef_t            coef_r;
  aff_pkg::cfg_reg_t         ridx;
  logic                      wr;
  logic                      push, q_full, q_pop, q_empty;
  aff_pkg::ent_t             push_ent, pop_ent;
  logic [aff_pkg::DW-1:0]    den;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign ridx   = aff_pkg::cfg_reg_t'(paddr[aff_pkg::CFG_AW-1:2]);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.a  <= ONE;
      coef_r.b  <= '0;
      coef_r.tx <= '0;
      coef_r.c  <= '0;
      coef_r.d  <= ONE;
      coef_r.ty <= '0;
    end else if (wr) begin
      case (ridx)
        aff_pkg::REG_COEF_A:  coef_r.a  <= pwdata;
        aff_pkg::REG_COEF_B:  coef_r.b  <= pwdata;
        aff_pkg::REG_SHIFT_X: coef_r.tx <= pwdata;
        aff_pkg::REG_COEF_C:  coef_r.c  <= pwdata;
        aff_pkg::REG_COEF_D:  coef_r.d  <= pwdata;
        aff_pkg::REG_SHIFT_Y: coef_r.ty <= pwdata;
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    case (ridx)
      aff_pkg::REG_COEF_A:  prdata = coef_r.a;
      aff_pkg::REG_COEF_B:  prdata = coef_r.b;
      aff_pkg::REG_SHIFT_X: prdata = coef_r.tx;
      aff_pkg::REG_COEF_C:  prdata = coef_r.c;
      aff_pkg::REG_COEF_D:  prdata = coef_r.d;
      aff_pkg::REG_SHIFT_Y: prdata = coef_r.ty;
      default:              prdata = '0;
    endcase
  end

  aff_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .coef     (coef_r),
    .in_valid (in_pt.valid),
    .in_ready (in_pt.ready),
    .in_mode  (in_pt.mode),
    .in_x     (in_pt.in_x),
    .in_y     (in_pt.in_y),
    .push     (push),
    .push_ent (push_ent),
    .q_full   (q_full),
    .den      (den)
  );

  aff_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .full     (q_full),
    .pop      (q_pop),
    .pop_ent  (pop_ent),
    .empty    (q_empty)
  );

  aff_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .den       (den),
    .q_empty   (q_empty),
    .q_ent     (pop_ent),
    .q_pop     (q_pop),
    .out_valid (out_pt.valid),
    .out_ready (out_pt.ready),
    .out_x     (out_pt.out_x),
    .out_y     (out_pt.out_y),
    .singular  (out_pt.singular),
    .overflow  (out_pt.overflow)
  );

endmodule

`default_nettype wire

// ===== src/aff_chk.sv =====
// port-level checks for the affine point transform, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module aff_chk (
  input wire        clk,
  input wire        rst_n,
  aff_out_if.source out_pt,
  input wire        pready
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_pt.valid && !out_pt.ready |=> out_pt.valid)
    else $error("result withdrawn while stalled");

  // a held result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_pt.valid && !out_pt.ready |=>
      $stable(out_pt.out_x) && $stable(out_pt.out_y) &&
      $stable(out_pt.singular) && $stable(out_pt.overflow))
    else $error("stalled result changed");

  // singular results are zero and never saturated
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_pt.valid && out_pt.singular |->
      out_pt.out_x == '0 && out_pt.out_y == '0 && !out_pt.overflow)
    else $error("singular result not cleared");

  // reset empties the result side
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_pt.valid)
    else $error("result valid after reset");

  // no wait states on the register port
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("register port stalled");

endmodule

bind affine_2d_point_transform aff_chk u_chk (
  .clk    (clk),
  .rst_n  (rst_n),
  .out_pt (out_pt),
  .pready (pready)
);

`default_nettype wire

// ===== sim/testbench.sv =====
// testbench for the affine point transform: stream of points checked against a local predictor
`timescale 1ns / 1ps

module testbench;

  localparam int FRAC = aff_pkg::FRAC_BITS_DEF;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 48;

  typedef struct {
    logic mode;
    logic signed [aff_pkg::CW-1:0] x;
    logic signed [aff_pkg::CW-1:0] y;
  } point_t;

  typedef struct {
    logic signed [aff_pkg::CW-1:0] x;
    logic signed [aff_pkg::CW-1:0] y;
    logic sing;
    logic ovf;
  } mapped_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [aff_pkg::CFG_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  aff_in_if  in_pt();
  aff_out_if out_pt();

  affine_2d_point_transform u_top (
    .clk(clk), .rst_n(rst_n), .in_pt(in_pt.sink), .out_pt(out_pt.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // matrix copy held by the testbench
  logic signed [aff_pkg::CW-1:0] coef [6];

  point_t  points_to_send [$];
  mapped_t points_due [$];
  int errors = 0;
  int send_gap = 0;
  int stall_left = 0;
  bit steady = 0;
  bit in_taken = 0;
  int idle_cycles = 0;

  // clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // saturate a wide signed value to a coordinate
  function automatic logic signed [aff_pkg::CW-1:0] clip32(input logic signed [127:0] v,
                                                           inout bit ovf);
    if (v > 128'sd2147483647) begin
      ovf = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -128'sd2147483648) begin
      ovf = 1'b1;
      return 32'sh80000000;
    end
    return v[aff_pkg::CW-1:0];
  endfunction

  // one forward coordinate: round half up on the product sum, then translate
  function automatic logic signed [aff_pkg::CW-1:0] fwd_coord(input logic signed [127:0] m0,
      input logic signed [127:0] m1, input logic signed [127:0] t,
      input logic signed [127:0] x, input logic signed [127:0] y, inout bit ovf);
    logic signed [127:0] acc;
    acc = m0 * x + m1 * y + (128'sd1 <<< (FRAC - 1));
    acc = (acc >>> FRAC) + t;
    return clip32(acc, ovf);
  endfunction

  // one inverse coordinate: (p - q) scaled and divided by det, ties away from zero
  function automatic logic signed [aff_pkg::CW-1:0] inv_coord(input logic signed [127:0] p,
      input logic signed [127:0] q, input logic signed [127:0] det, inout bit ovf);
    logic signed [127:0] num, mag, quo;
    bit neg;
    num = p - q;
    neg = num < 0;
    if (neg) num = -num;
    mag = (det < 0) ? -det : det;
    if (det < 0) neg = !neg;
    num = (num <<< FRAC) + (mag >>> 1);
    quo = num / mag;
    if (neg) quo = -quo;
    return clip32(quo, ovf);
  endfunction

  // expected result of one point under the current matrix
  function automatic mapped_t map_point(input point_t p);
    mapped_t r;
    bit ovf;
    logic signed [127:0] a, b, tx, c, d, ty, x, y, det, dx, dy;
    a = coef[aff_pkg::REG_COEF_A];
    b = coef[aff_pkg::REG_COEF_B];
    tx = coef[aff_pkg::REG_SHIFT_X];
    c = coef[aff_pkg::REG_COEF_C];
    d = coef[aff_pkg::REG_COEF_D];
    ty = coef[aff_pkg::REG_SHIFT_Y];
    x = p.x;
    y = p.y;
    ovf = 1'b0;
    r.x = '0;
    r.y = '0;
    r.sing = 1'b0;
    if (p.mode == aff_pkg::MODE_FWD) begin
      r.x = fwd_coord(a, b, tx, x, y, ovf);
      r.y = fwd_coord(c, d, ty, x, y, ovf);
    end else begin
      det = a * d - b * c;
      if (det == 0) begin
        r.sing = 1'b1;
      end else begin
        dx = x - tx;
        dy = y - ty;
        r.x = inv_coord(d * dx, b * dy, det, ovf);
        r.y = inv_coord(a * dy, c * dx, det, ovf);
      end
    end
    r.ovf = ovf;
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    errors++;
    $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
  endtask

  // gap length: mostly none or short, sometimes long
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // input driver
  always @(negedge clk) begin
    point_t p;
    if (!rst_n) begin
      in_pt.valid <= 1'b0;
    end else if (!in_pt.valid || in_taken) begin
      if (send_gap > 0) begin
        in_pt.valid <= 1'b0;
        send_gap--;
      end else if (points_to_send.size() > 0) begin
        p = points_to_send.pop_front();
        in_pt.valid <= 1'b1;
        in_pt.mode <= p.mode;
        in_pt.in_x <= p.x;
        in_pt.in_y <= p.y;
        send_gap = steady ? 0 : rand_gap();
      end else begin
        in_pt.valid <= 1'b0;
      end
    end
  end

  // result back pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_pt.ready <= 1'b0;
    end else if (steady) begin
      out_pt.ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_pt.ready <= 1'b0;
      stall_left--;
    end else begin
      out_pt.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = rand_gap();
    end
  end

  // monitor: accepted points become expectations, accepted results are checked
  always @(posedge clk) begin
    point_t p;
    mapped_t want;
    in_taken = rst_n && in_pt.valid && in_pt.ready;
    if (in_taken) begin
      p.mode = in_pt.mode;
      p.x = in_pt.in_x;
      p.y = in_pt.in_y;
      points_due = {points_due, map_point(p)};
    end
    if (rst_n && out_pt.valid && out_pt.ready) begin
      if (points_due.size() == 0) begin
        report("unexpected item", 32'h0, out_pt.out_x);
      end else begin
        want = points_due.pop_front();
        if (out_pt.out_x !== want.x) report("out_x", want.x, out_pt.out_x);
        if (out_pt.out_y !== want.y) report("out_y", want.y, out_pt.out_y);
        if (out_pt.singular !== want.sing)
          report("singular", 32'(want.sing), 32'(out_pt.singular));
        if (out_pt.overflow !== want.ovf)
          report("overflow", 32'(want.ovf), 32'(out_pt.overflow));
      end
    end
  end

  // watchdog on cycles with no item moving and no register access
  always @(posedge clk) begin
    if ((in_pt.valid && in_pt.ready) || (out_pt.valid && out_pt.ready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[affine_2d_point_transform] ERROR");
      $finish;
    end
  end

  task automatic write_reg(input aff_pkg::cfg_reg_t idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= aff_pkg::CFG_AW'({idx, 2'b00});
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    coef[idx] = value;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_matrix(input logic [31:0] a, input logic [31:0] b, input logic [31:0] tx,
                            input logic [31:0] c, input logic [31:0] d, input logic [31:0] ty);
    write_reg(aff_pkg::REG_COEF_A, a);
    write_reg(aff_pkg::REG_COEF_B, b);
    write_reg(aff_pkg::REG_SHIFT_X, tx);
    write_reg(aff_pkg::REG_COEF_C, c);
    write_reg(aff_pkg::REG_COEF_D, d);
    write_reg(aff_pkg::REG_SHIFT_Y, ty);
  endtask

  // wait until every point has gone through, then let the pipe settle
  task automatic drain();
    while (points_to_send.size() > 0 || in_pt.valid || points_due.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] near_value();
    return $urandom_range(0, 8 << FRAC) - (4 << FRAC);
  endfunction

  function automatic logic [31:0] rand_value();
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return $urandom();
    if (r == 1) return $urandom_range(0, 8) == 0 ? 32'h0 : $urandom_range(0, 255) - 128;
    return near_value();
  endfunction

  task automatic add_point(input logic mode, input logic [31:0] x, input logic [31:0] y);
    point_t p;
    p.mode = mode;
    p.x = x;
    p.y = y;
    points_to_send = {points_to_send, p};
  endtask

  task automatic add_random(input int count);
    repeat (count) add_point(1'($urandom_range(0, 1)), rand_value(), rand_value());
  endtask

  // stimulus sequence
  initial begin
    logic [31:0] s, t;
    int m;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    coef[aff_pkg::REG_COEF_A] = 32'sd1 <<< FRAC;
    coef[aff_pkg::REG_COEF_B] = '0;
    coef[aff_pkg::REG_SHIFT_X] = '0;
    coef[aff_pkg::REG_COEF_C] = '0;
    coef[aff_pkg::REG_COEF_D] = 32'sd1 <<< FRAC;
    coef[aff_pkg::REG_SHIFT_Y] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed points under the reset matrix
    for (int md = 0; md < 2; md++) begin
      add_point(1'(md), 32'h0, 32'h0);
      add_point(1'(md), 32'h7fffffff, 32'h7fffffff);
      add_point(1'(md), 32'h80000000, 32'h80000000);
      add_point(1'(md), 32'h7fffffff, 32'h80000000);
      add_point(1'(md), 32'h80000000, 32'h7fffffff);
      add_point(1'(md), 32'h00018000, 32'hffff8000);
    end
    add_random(100);
    drain();

    // extreme matrices, then singular ones, then a tiny-scale one, then random settings
    for (int ph = 0; ph < 10; ph++) begin
      steady = (ph % 3 == 2);
      case (ph)
        0: set_matrix(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                      32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        1: set_matrix(32'h80000000, 32'h80000000, 32'h80000000,
                      32'h80000000, 32'h80000000, 32'h80000000);
        2: set_matrix(32'h80000000, 32'h7fffffff, 32'h0, 32'h7fffffff, 32'h80000000, 32'h1);
        3: set_matrix(32'h0, 32'h0, 32'h7fffffff, 32'h0, 32'h0, 32'h80000000);
        4: begin
          // rows proportional, so the determinant is zero
          s = near_value();
          t = near_value();
          m = $urandom_range(0, 6) - 3;
          set_matrix(s, t, rand_value(), s * m, t * m, rand_value());
        end
        5: set_matrix(32'h1, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0);
        default: set_matrix(rand_value(), rand_value(), rand_value(),
                            rand_value(), rand_value(), rand_value());
      endcase
      if (ph == 0) begin
        add_point(aff_pkg::MODE_FWD, 32'h7fffffff, 32'h7fffffff);
        add_point(aff_pkg::MODE_INV, 32'h80000000, 32'h80000000);
      end
      add_random(150);
      drain();
    end

    steady = 1'b0;
    if (errors == 0) begin
      $display("[affine_2d_point_transform] OK");
    end else begin
      $display("[affine_2d_point_transform] ERROR");
    end
    $finish;
  end

endmodule
